// File: rtl/mwc_keystream_xor_decryptor_core_defines.svh
// assertion macros used by the checker file
`ifndef MWC_KEYSTREAM_XOR_DECRYPTOR_CORE_DEFINES_SVH
`define MWC_KEYSTREAM_XOR_DECRYPTOR_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MWCXD_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mwcxd assertion failed");

// next-cycle implication, disabled while reset is asserted
`define MWCXD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mwcxd assertion failed");

`endif

// File: rtl/mwcxd_pkg.sv
// ----------------------------------------------------------------------------
// mwcxd_pkg
// shared types and constants of the multiply-with-carry xor decryptor
// ----------------------------------------------------------------------------
`default_nettype none

package mwcxd_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned MultW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 3;
  localparam int unsigned PrefW  = 9;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [MultW-1:0]  MultARst   = 16'd36969;
  localparam logic [MultW-1:0]  MultBRst   = 16'd18000;
  localparam logic [PrefW-1:0]  PrefixBase = 9'd6;
  localparam logic [CountW-1:0] CountByte  = 3'd1;
  localparam logic [CountW-1:0] CountDword = 3'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSeedA = 2'd0,
    CfgSeedB = 2'd1,
    CfgMultA = 2'd2,
    CfgMultB = 2'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

// File: rtl/mwc_keystream_xor_decryptor_core.sv
// ----------------------------------------------------------------------------
// mwc_keystream_xor_decryptor_core: multiply-with-carry xor stream decryptor
// latency: a result beat is valid the cycle after the byte beat that causes it
// throughput: one byte beat per cycle unless a result is stalled at the output, set by the single result register
// reset: config to defaults, stream state cleared, no result pending
// ----------------------------------------------------------------------------
`default_nettype none

module mwc_keystream_xor_decryptor_core
  import mwcxd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // config write channel
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [WordW-1:0]  cfg_data_i,
  // byte input channel
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ByteW-1:0]  data_byte_i,
  input  wire logic              last_byte_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [WordW-1:0]       out_data_o,
  output logic [CountW-1:0]      out_count_o,
  output logic                   out_last_o
);

  // config registers
  logic [WordW-1:0] seed_a_q, seed_b_q;
  logic [MultW-1:0] mult_a_q, mult_b_q;

  // stream state
  logic [WordW-1:0] gen_a_q, gen_a_d;
  logic [WordW-1:0] gen_b_q, gen_b_d;
  logic [PrefW-1:0] prefix_q, prefix_d;
  logic [23:0]      bytes_q, bytes_d;
  logic [1:0]       fill_q, fill_d;
  logic             loaded_q, loaded_d;

  // result register
  logic             out_valid_q;
  logic [WordW-1:0] out_data_q, out_data_d;
  logic [CountW-1:0] out_count_q, out_count_d;
  logic             out_last_q;
  logic             res_valid_d;

  // working values, seeds take over when a new stream starts
  logic [WordW-1:0] gen_a_eff, gen_b_eff;
  logic [PrefW-1:0] prefix_eff;
  logic [23:0]      bytes_eff;
  logic [1:0]       fill_eff;
  logic [WordW-1:0] prod_a, prod_b, next_a, next_b, mask, dword;

  logic in_fire;

  assign cfg_ready_o = 1'b1;
  // the result register frees up in the same cycle it is drained
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  assign gen_a_eff  = loaded_q ? gen_a_q  : seed_a_q;
  assign gen_b_eff  = loaded_q ? gen_b_q  : seed_b_q;
  assign prefix_eff = loaded_q ? prefix_q : ({1'b0, seed_b_q[7:0]} + PrefixBase);
  assign bytes_eff  = loaded_q ? bytes_q  : 24'h0;
  assign fill_eff   = loaded_q ? fill_q   : 2'd0;

  // two independent 16x16 multiply-with-carry steps
  assign prod_a = {16'h0, gen_a_eff[15:0]} * {16'h0, mult_a_q};
  assign prod_b = {16'h0, gen_b_eff[15:0]} * {16'h0, mult_b_q};
  assign next_a = prod_a + {16'h0, gen_a_eff[31:16]};
  assign next_b = prod_b + {16'h0, gen_b_eff[31:16]};
  // (a << 16) + (b & 0xffff) never carries across the halves
  assign mask   = {next_a[15:0], next_b[15:0]};
  assign dword  = {data_byte_i, bytes_eff};

  always_comb begin
    gen_a_d     = gen_a_eff;
    gen_b_d     = gen_b_eff;
    prefix_d    = prefix_eff;
    bytes_d     = bytes_eff;
    fill_d      = fill_eff;
    loaded_d    = 1'b1;
    res_valid_d = 1'b0;
    out_data_d  = '0;
    out_count_d = CountDword;

    if (prefix_eff != '0) begin
      // plain prefix byte
      prefix_d    = prefix_eff - 9'd1;
      res_valid_d = 1'b1;
      out_data_d  = {24'h0, data_byte_i};
      out_count_d = CountByte;
    end else if (fill_eff == 2'd3) begin
      // group complete, step both generators
      gen_a_d     = next_a;
      gen_b_d     = next_b;
      res_valid_d = 1'b1;
      out_data_d  = dword ^ mask;
      bytes_d     = '0;
      fill_d      = 2'd0;
    end else if (last_byte_i) begin
      // short tail gives a zero dword, generators hold
      res_valid_d = 1'b1;
    end else begin
      // gather one more byte little-endian
      case (fill_eff)
        2'd0:    bytes_d = {bytes_eff[23:8], data_byte_i};
        2'd1:    bytes_d = {bytes_eff[23:16], data_byte_i, bytes_eff[7:0]};
        default: bytes_d = {data_byte_i, bytes_eff[15:0]};
      endcase
      fill_d = fill_eff + 2'd1;
    end

    // end of stream clears everything but the generator words
    if (last_byte_i) begin
      loaded_d = 1'b0;
      prefix_d = '0;
      bytes_d  = '0;
      fill_d   = 2'd0;
    end
  end

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_a_q <= '0;
      seed_b_q <= '0;
      mult_a_q <= MultARst;
      mult_b_q <= MultBRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgSeedA: seed_a_q <= cfg_data_i;
        CfgSeedB: seed_b_q <= cfg_data_i;
        CfgMultA: mult_a_q <= cfg_data_i[MultW-1:0];
        CfgMultB: mult_b_q <= cfg_data_i[MultW-1:0];
        default:  ;
      endcase
    end
  end

  // stream state and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_a_q     <= '0;
      gen_b_q     <= '0;
      prefix_q    <= '0;
      bytes_q     <= '0;
      fill_q      <= 2'd0;
      loaded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      gen_a_q     <= gen_a_d;
      gen_b_q     <= gen_b_d;
      prefix_q    <= prefix_d;
      bytes_q     <= bytes_d;
      fill_q      <= fill_d;
      loaded_q    <= loaded_d;
      out_valid_q <= res_valid_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid_d) begin
      out_data_q  <= out_data_d;
      out_count_q <= out_count_d;
      out_last_q  <= last_byte_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_count_o = out_count_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// File: rtl/mwcxd_checker.sv
// ----------------------------------------------------------------------------
// mwcxd_checker
// port-level checks on the decryptor, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "mwc_keystream_xor_decryptor_core_defines.svh"

module mwcxd_checker
  import mwcxd_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [WordW-1:0]   out_data_o,
  input wire logic [CountW-1:0]  out_count_o,
  input wire logic               out_last_o
);

  // only a stalled result may hold off input
  `MWCXD_ASSERT_NOW(a_ready_only_on_stall, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // a prefix beat carries just one byte
  `MWCXD_ASSERT_NOW(a_byte_beat_narrow, clk_i, rst_ni, out_valid_o && (out_count_o == CountByte), out_data_o[31:8] == 24'h0)

  // a drained result with no new byte leaves the output empty
  `MWCXD_ASSERT_NEXT(a_drain_empties, clk_i, rst_ni, out_valid_o && out_ready_i && !in_valid_i, !out_valid_o)

  // a stalled result holds
  `MWCXD_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o) && $stable(out_count_o) && $stable(out_last_o))

endmodule

bind mwc_keystream_xor_decryptor_core mwcxd_checker u_mwcxd_checker (.*);

`default_nettype wire
